[rtl/core/smi_pkg.sv]
`default_nettype none
package smi_pkg;

  // result element width, Q(24-F).F
  localparam int RES_W = 24;

  // stage counts
  localparam int COF_LAT = 4;
  localparam int DIV_LAT = RES_W + 3;

  // dimension register codes
  localparam logic [1:0] DIM_2 = 2'd2;
  localparam logic [1:0] DIM_3 = 2'd3;

  typedef struct packed {
    logic [RES_W-1:0] res;
    logic             ovf;
    logic             dz;
  } lane_out_t;

endpackage
`default_nettype wire

[rtl/core/smi_cofactor.sv]
`default_nettype none
module smi_cofactor #(
  parameter int DW = 16
) (
  input  wire logic                    clk_i,
  input  wire logic                    en_i,
  input  wire logic [1:0]              dim_i,
  input  wire logic signed [DW-1:0]    m_i   [9],
  output logic signed [2*DW:0]         adj_o [9],
  output logic signed [3*DW+1:0]       det_o
);
  import smi_pkg::*;

  localparam int PRW  = 2 * DW;
  localparam int CW   = 2 * DW + 1;
  localparam int DETW = 3 * DW + 2;
  localparam int PW   = DW + CW;

  logic signed [DW-1:0]   m1_q [9];
  logic signed [DW-1:0]   m2_q [9];
  logic signed [DW-1:0]   m3_q [9];
  logic signed [2*DW-1:0] pa_q [9];
  logic signed [2*DW-1:0] pb_q [9];
  logic signed [CW-1:0]   cof2_q [9];
  logic signed [CW-1:0]   cof3_q [9];
  logic signed [PW-1:0]   dp_q [3];
  logic signed [CW-1:0]   adj_d [9];
  logic signed [CW-1:0]   adj_q [9];
  logic signed [DETW-1:0] det_d, det_q, det3;

  // minor products, one pair per element
  for (genvar r = 0; r < 3; r++) begin : g_r
    for (genvar c = 0; c < 3; c++) begin : g_c
      localparam int R1 = (r + 1) % 3;
      localparam int R2 = (r + 2) % 3;
      localparam int C1 = (c + 1) % 3;
      localparam int C2 = (c + 2) % 3;
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          pa_q[r*3+c]   <= PRW'(m_i[R1*3+C1]) * PRW'(m_i[R2*3+C2]);
          pb_q[r*3+c]   <= PRW'(m_i[R1*3+C2]) * PRW'(m_i[R2*3+C1]);
          cof2_q[r*3+c] <= CW'(pa_q[r*3+c]) - CW'(pb_q[r*3+c]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m1_q   <= m_i;
      m2_q   <= m1_q;
      m3_q   <= m2_q;
      cof3_q <= cof2_q;
      for (int c = 0; c < 3; c++) begin
        dp_q[c] <= PW'(m2_q[c]) * PW'(cof2_q[c]);
      end
      adj_q <= adj_d;
      det_q <= det_d;
    end
  end

  assign det3 = DETW'(dp_q[0]) + DETW'(dp_q[1]) + DETW'(dp_q[2]);

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      adj_d[k] = '0;
    end
    case (dim_i)
      DIM_3: begin
        det_d = det3;
        for (int r = 0; r < 3; r++) begin
          for (int c = 0; c < 3; c++) begin
            adj_d[c*3+r] = cof3_q[r*3+c];
          end
        end
      end
      DIM_2: begin
        // 2x2 determinant equals the 3x3 cofactor of the corner element
        det_d    = DETW'(cof3_q[8]);
        adj_d[0] = CW'(m3_q[4]);
        adj_d[1] = -CW'(m3_q[1]);
        adj_d[3] = -CW'(m3_q[3]);
        adj_d[4] = CW'(m3_q[0]);
      end
      default: begin
        det_d    = DETW'(m3_q[0]);
        adj_d[0] = CW'(1);
      end
    endcase
  end

  assign adj_o = adj_q;
  assign det_o = det_q;

endmodule
`default_nettype wire

[rtl/core/smi_div_lane.sv]
`default_nettype none
module smi_div_lane #(
  parameter int DW = 16,
  parameter int FB = 12
) (
  input  wire logic                   clk_i,
  input  wire logic                   en_i,
  input  wire logic signed [2*DW:0]   cof_i,
  input  wire logic signed [3*DW+1:0] det_i,
  output smi_pkg::lane_out_t          out_o
);
  import smi_pkg::*;

  localparam int CW   = 2 * DW + 1;
  localparam int DETW = 3 * DW + 2;
  localparam int NUMW = CW + 2 * FB;
  localparam int RW   = ((NUMW > DETW + RES_W) ? NUMW : DETW + RES_W) + 1;

  logic [CW-1:0]   cmag_q;
  logic [DETW-1:0] dmag_q;
  logic            neg_a_q, dz_a_q;
  logic [RW-1:0]   nb, db;

  logic [RW-1:0]    r_q   [RES_W];
  logic [RW-1:0]    d_q   [RES_W];
  logic [RES_W-1:0] q_q   [RES_W+1];
  logic             neg_q [RES_W+1];
  logic             dz_q  [RES_W+1];
  logic             ovf_q [RES_W+1];

  logic [RES_W-1:0] lim, mag, q_f;
  logic             ov;
  lane_out_t        out_d, out_q;

  // magnitudes, sign of the quotient and the zero-divisor flag
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cmag_q  <= cof_i[CW-1] ? CW'(-cof_i) : CW'(cof_i);
      dmag_q  <= det_i[DETW-1] ? DETW'(-det_i) : DETW'(det_i);
      neg_a_q <= cof_i[CW-1] ^ det_i[DETW-1];
      dz_a_q  <= (det_i == '0);
    end
  end

  assign nb = RW'(cmag_q) << (2 * FB);
  assign db = RW'(dmag_q);

  // quotient of more than RES_W bits saturates regardless of sign
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]   <= nb;
      d_q[0]   <= db;
      q_q[0]   <= '0;
      neg_q[0] <= neg_a_q;
      dz_q[0]  <= dz_a_q;
      ovf_q[0] <= nb >= (db << RES_W);
    end
  end

  // restoring division, one quotient bit per stage, MSB first
  for (genvar i = 0; i < RES_W; i++) begin : g_stg
    localparam int B = RES_W - 1 - i;
    logic [RW-1:0] t;
    logic          ge;
    assign t  = d_q[i] << B;
    assign ge = r_q[i] >= t;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        q_q[i+1]   <= {q_q[i][RES_W-2:0], ge};
        neg_q[i+1] <= neg_q[i];
        dz_q[i+1]  <= dz_q[i];
        ovf_q[i+1] <= ovf_q[i];
      end
    end
    if (i < RES_W - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          r_q[i+1] <= ge ? r_q[i] - t : r_q[i];
          d_q[i+1] <= d_q[i];
        end
      end
    end
  end

  assign q_f = q_q[RES_W];

  always_comb begin
    lim = neg_q[RES_W] ? {1'b1, {(RES_W-1){1'b0}}} : {1'b0, {(RES_W-1){1'b1}}};
    ov  = ovf_q[RES_W] | (q_f > lim);
    mag = ov ? lim : q_f;
    out_d.dz = dz_q[RES_W];
    if (dz_q[RES_W]) begin
      out_d.res = '0;
      out_d.ovf = 1'b0;
    end else begin
      out_d.res = neg_q[RES_W] ? -mag : mag;
      out_d.ovf = ov;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q <= out_d;
    end
  end

  assign out_o = out_q;

endmodule
`default_nettype wire

[rtl/core/small_matrix_inverse.sv]
// Pipeline from input accept to m_axis_tvalid: input register, 4 cofactor
//   stages, 27 divider stages, output register.
// Throughput: one matrix per cycle while the output is not stalled; nine divider lanes, one bit per stage each.
// Stalls freeze the whole pipeline while the output register holds an untaken result.
// Reset: asynchronous active low; clears valid bits, dimension returns to 3.
`default_nettype none
module small_matrix_inverse #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 12
) (
  input  wire logic                                        clk_i,
  input  wire logic                                        rst_ni,
  // APB configuration
  input  wire logic                                        psel,
  input  wire logic                                        penable,
  input  wire logic                                        pwrite,
  input  wire logic [2:0]                                  paddr,
  input  wire logic [31:0]                                 pwdata,
  output logic [31:0]                                      prdata,
  output logic                                             pready,
  // input matrix
  input  wire logic                                        s_axis_tvalid,
  output logic                                             s_axis_tready,
  // e00,e01,e02,e10,e11,e12,e20,e21,e22 from bit 0 up, zero padded to bytes
  input  wire logic [((9*DATA_WIDTH+7)/8)*8-1:0]           s_axis_tdata,
  // inverse
  output logic                                             m_axis_tvalid,
  input  wire logic                                        m_axis_tready,
  // r00,r01,r02,r10,r11,r12,r20,r21,r22 from bit 0 up
  output logic [9*smi_pkg::RES_W-1:0]                      m_axis_tdata,
  // bit 0 singular, bit 1 overflow
  output logic [1:0]                                       m_axis_tuser
);
  import smi_pkg::*;

  localparam int DW   = DATA_WIDTH;
  localparam int CW   = 2 * DW + 1;
  localparam int DETW = 3 * DW + 2;
  localparam int LAT  = 1 + COF_LAT + DIV_LAT + 1;

  // config register
  logic [1:0] dim_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q <= DIM_3;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      dim_q <= pwdata[1:0];
    end
  end
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {30'd0, dim_q};

  // one enable for the whole pipe: advance unless the output holds a stalled request
  logic           en;
  logic [LAT-1:0] vld_q;
  assign en            = !vld_q[LAT-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
    end
  end

  // input register
  logic signed [DW-1:0] m_q [9];
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        m_q[k] <= s_axis_tdata[k*DW +: DW];
      end
    end
  end

  // adjugate and determinant
  logic signed [CW-1:0]   adj [9];
  logic signed [DETW-1:0] det;

  smi_cofactor #(.DW(DW)) u_cof (
    .clk_i (clk_i),
    .en_i  (en),
    .dim_i (dim_q),
    .m_i   (m_q),
    .adj_o (adj),
    .det_o (det)
  );

  // one divider lane per element; inactive positions carry a zero cofactor
  lane_out_t lane [9];
  for (genvar k = 0; k < 9; k++) begin : g_lane
    smi_div_lane #(.DW(DW), .FB(FRAC_BITS)) u_lane (
      .clk_i (clk_i),
      .en_i  (en),
      .cof_i (adj[k]),
      .det_i (det),
      .out_o (lane[k])
    );
  end

  // merge: pack results, OR the saturation flags
  logic [9*RES_W-1:0] data_d;
  logic               ovf_d;
  always_comb begin
    ovf_d = 1'b0;
    for (int k = 0; k < 9; k++) begin
      data_d[k*RES_W +: RES_W] = lane[k].res;
      ovf_d = ovf_d | lane[k].ovf;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_axis_tdata <= data_d;
      m_axis_tuser <= {ovf_d, lane[0].dz};
    end
  end

endmodule
`default_nettype wire

[rtl/core/smi_checker.sv]
`default_nettype none
module smi_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tready,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [215:0] m_axis_tdata,
  input wire logic [1:0]   m_axis_tuser
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  a_sing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("singular result not zero");

  a_sing_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tuser[1])
    else $error("singular with overflow");

endmodule

bind small_matrix_inverse smi_checker u_smi_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
